// ===== hdl/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg
// Shared widths, constants and result type for the six-bit text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    localparam int STE_COUNT_BITS = 16;
    localparam int LIMIT_W        = 16;
    localparam int CHAR_W         = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hffff;
    localparam logic [CHAR_W-1:0]  CHAR_BIAS   = 7'h3c;
    localparam logic [5:0]         GROUP_MASK  = 6'h3f;

    // Group phase codes: bytes already taken in the current 3-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // Number of results produced by one byte
    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_ONE  = 2'd1;
    localparam logic [1:0] NUM_TWO  = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              has_char;
        logic              last_char;
    } ste_res_t;

endpackage

`default_nettype wire

// ===== hdl/six_bit_text_encoder.sv =====
// ----------------------------------------------------------------------------
// six_bit_text_encoder
// Packs bytes big-endian into 6-bit groups sent out as characters (group+60).
// ----------------------------------------------------------------------------
//  channel  direction  content
//  s_*      in         data_byte in tdata, last_byte in tlast
//  m_*      out        code_char in tdata, has_char in tuser, last_char in tlast
//  cfg_*    in         output_limit, written at any edge with cfg_wr_en high
//
//  A byte's first character appears on m_* in the cycle after its acceptance.
//  Bytes that yield at most one result stream at one per cycle unless m_*
//  stalls; a byte with two results holds the two-slot result register until
//  both are taken. Reset clears the packing state and result count and sets
//  the limit to 65535. A stall on m_* holds s_tready low with results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module six_bit_text_encoder import ste_pkg::*; #(
    parameter int COUNT_BITS = STE_COUNT_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data,   // output_limit

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,       // [7:0] data_byte
    input  wire logic               s_tlast,       // last_byte

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,       // [6:0] code_char, [7] zero
    output logic [0:0]              m_tuser,       // [0] has_char
    output logic                    m_tlast        // last_char
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               take;
    ste_res_t           res0, res1, out_res;
    logic [1:0]         num_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign take = s_tvalid && s_tready;

    ste_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .data_byte    (s_tdata),
        .last_byte    (s_tlast),
        .output_limit (limit_reg),
        .res0         (res0),
        .res1         (res1),
        .num_res      (num_res)
    );

    ste_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take),
        .num_res    (num_res),
        .res0       (res0),
        .res1       (res1),
        .load_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {1'b0, out_res.code_char};
    assign m_tuser = out_res.has_char;
    assign m_tlast = out_res.last_char;

endmodule

`default_nettype wire

// ===== hdl/ste_core.sv =====
// ----------------------------------------------------------------------------
// ste_core
// Byte-to-character step: packing state, output limit and end-of-buffer flush.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_core import ste_pkg::*; #(
    parameter int COUNT_BITS = STE_COUNT_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               take,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic [LIMIT_W-1:0] output_limit,
    output ste_res_t                res0,
    output ste_res_t                res1,
    output logic [1:0]              num_res
);

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [5:0]            leftover_reg, leftover_next;
    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] chars_reg, chars_next;

    logic [5:0]            made, rest;
    logic [COUNT_BITS-1:0] chars_p1, chars_p2;
    logic                  room0, room1;

    assign chars_p1 = chars_reg + COUNT_BITS'(1);
    assign chars_p2 = chars_reg + COUNT_BITS'(2);

    // Effective limit is min(output_limit, counter max)
    assign room0 = (chars_reg != COUNT_MAX) &&
                   (CMP_W'(chars_reg) < CMP_W'(output_limit));
    assign room1 = room0 && (chars_p1 != COUNT_MAX) &&
                   (CMP_W'(chars_p1) < CMP_W'(output_limit));

    always_comb begin
        case (phase_reg)
            PHASE_0: begin
                made = leftover_reg | data_byte[7:2];
                rest = {data_byte[1:0], 4'b0000};
            end
            PHASE_1: begin
                made = leftover_reg | {2'b00, data_byte[7:4]};
                rest = {data_byte[3:0], 2'b00};
            end
            default: begin
                made = leftover_reg | {4'b0000, data_byte[7:6]};
                rest = data_byte[5:0] & GROUP_MASK;
            end
        endcase
    end

    always_comb begin
        res0          = '0;
        res1          = '0;
        num_res       = NUM_NONE;
        leftover_next = leftover_reg;
        phase_next    = phase_reg;
        chars_next    = chars_reg;

        if (room0) begin
            res0    = '{code_char: {1'b0, made} + CHAR_BIAS, has_char: 1'b1,
                        last_char: 1'b0};
            num_res = NUM_ONE;
            if (phase_reg inside {PHASE_0, PHASE_1}) begin
                chars_next    = chars_p1;
                leftover_next = rest;
                phase_next    = phase_reg + 2'd1;
                // flush the fresh leftover on the last byte if room remains
                if (last_byte && room1) begin
                    res1    = '{code_char: {1'b0, rest} + CHAR_BIAS, has_char: 1'b1,
                                last_char: 1'b0};
                    num_res = NUM_TWO;
                end
            end else begin
                chars_next    = chars_p1;
                leftover_next = '0;
                phase_next    = PHASE_0;
                // drop the second character when only one slot is left
                if (room1) begin
                    res1       = '{code_char: {1'b0, rest} + CHAR_BIAS, has_char: 1'b1,
                                   last_char: 1'b0};
                    num_res    = NUM_TWO;
                    chars_next = chars_p2;
                end
            end
        end

        if (last_byte) begin
            if (num_res == NUM_NONE) begin
                res0    = '{code_char: '0, has_char: 1'b0, last_char: 1'b1};
                num_res = NUM_ONE;
            end else if (num_res == NUM_TWO) begin
                res1.last_char = 1'b1;
            end else begin
                res0.last_char = 1'b1;
            end
            leftover_next = '0;
            phase_next    = PHASE_0;
            chars_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leftover_reg <= '0;
            phase_reg    <= PHASE_0;
            chars_reg    <= '0;
        end else if (take) begin
            leftover_reg <= leftover_next;
            phase_reg    <= phase_next;
            chars_reg    <= chars_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PHASE_2)
        else $error("group phase out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && last_byte |=> phase_reg == PHASE_0 && chars_reg == '0 && leftover_reg == '0)
        else $error("state not cleared after last byte");

    a_phase0_no_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PHASE_0 |-> leftover_reg == '0)
        else $error("leftover bits held at group start");
`endif

endmodule

`default_nettype wire

// ===== hdl/ste_obuf.sv =====
// ----------------------------------------------------------------------------
// ste_obuf
// Two-slot result register: holds the results of one byte and drains them.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_obuf import ste_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire logic [1:0] num_res,
    input  ste_res_t        res0,
    input  ste_res_t        res1,
    output logic            load_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output ste_res_t        out_res
);

    ste_res_t   slot0_reg, slot0_next;
    ste_res_t   slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid  = (cnt_reg != NUM_NONE);
    assign out_res    = slot0_reg;
    assign pop        = out_valid && out_ready;
    // accept a new byte whenever the buffer will be empty at this edge
    assign load_ready = (cnt_reg == NUM_NONE) || (cnt_reg == NUM_ONE && out_ready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (load) begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = num_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= NUM_NONE;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NUM_TWO)
        else $error("result count out of range");

    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == NUM_NONE || (cnt_reg == NUM_ONE && pop))
        else $error("load would overwrite pending results");

    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && cnt_reg == NUM_TWO && !load |=> slot0_reg == $past(slot1_reg))
        else $error("second result not advanced");
`endif

endmodule

`default_nettype wire
